### hdl/kst_pkg.sv
// shared types and constants for the keyed slot table
package kst_pkg;

    localparam int KIND_W  = 2;
    localparam int KEY_W   = 64;
    localparam int ENTRY_W = 16;
    localparam int CODE_W  = 3;

    localparam int NUM_SLOTS_DEFAULT = 128;

    // request kinds
    localparam logic [KIND_W-1:0] REQ_ALLOC   = 2'd0;
    localparam logic [KIND_W-1:0] REQ_QUERY   = 2'd1;
    localparam logic [KIND_W-1:0] REQ_RELEASE = 2'd2;

    // result codes
    localparam logic [CODE_W-1:0] RES_ALLOCATED = 3'd0;
    localparam logic [CODE_W-1:0] RES_FULL      = 3'd1;
    localparam logic [CODE_W-1:0] RES_OCCUPIED  = 3'd2;
    localparam logic [CODE_W-1:0] RES_FREE      = 3'd3;
    localparam logic [CODE_W-1:0] RES_INVALID   = 3'd4;
    localparam logic [CODE_W-1:0] RES_RELEASED  = 3'd5;
    localparam logic [CODE_W-1:0] RES_NOT_FOUND = 3'd6;
    localparam logic [CODE_W-1:0] RES_UNKNOWN   = 3'd7;

    // request token that walks down the row of cells
    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [KEY_W-1:0]   key;
        logic [ENTRY_W-1:0] num;
        logic               done;
        logic [CODE_W-1:0]  code;
        logic [ENTRY_W-1:0] entry;
        logic [KEY_W-1:0]   rkey;
    } kst_token_t;

endpackage

### hdl/kst_cell.sv
// one table entry: occupied flag, key, and one stage of the request token
module kst_cell #(
    parameter int CELL_NUM = 1
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  logic                tok_valid_in,
    input  kst_pkg::kst_token_t tok_in,
    output logic                tok_valid_out,
    output kst_pkg::kst_token_t tok_out
);

    localparam logic [kst_pkg::ENTRY_W-1:0] MY_NUM = kst_pkg::ENTRY_W'(CELL_NUM);

    logic                        used_reg;
    logic                        used_next;
    logic [kst_pkg::KEY_W-1:0]   key_reg;
    logic [kst_pkg::KEY_W-1:0]   key_next;
    logic                        tok_valid_reg;
    kst_pkg::kst_token_t         tok_reg;
    kst_pkg::kst_token_t         tok_next;

    always_comb
    begin
        used_next = used_reg;
        key_next  = key_reg;
        tok_next  = tok_in;
        if (tok_valid_in && !tok_in.done)
        begin
            unique case (tok_in.kind)
                kst_pkg::REQ_ALLOC:
                begin
                    if (!used_reg)
                    begin
                        used_next      = 1'b1;
                        key_next       = tok_in.key;
                        tok_next.done  = 1'b1;
                        tok_next.code  = kst_pkg::RES_ALLOCATED;
                        tok_next.entry = MY_NUM;
                        tok_next.rkey  = tok_in.key;
                    end
                end
                kst_pkg::REQ_QUERY:
                begin
                    if (tok_in.num == MY_NUM)
                    begin
                        tok_next.done  = 1'b1;
                        tok_next.code  = used_reg ? kst_pkg::RES_OCCUPIED : kst_pkg::RES_FREE;
                        tok_next.entry = MY_NUM;
                        tok_next.rkey  = used_reg ? key_reg : tok_in.key;
                    end
                end
                kst_pkg::REQ_RELEASE:
                begin
                    if (used_reg && key_reg == tok_in.key)
                    begin
                        used_next      = 1'b0;
                        tok_next.done  = 1'b1;
                        tok_next.code  = kst_pkg::RES_RELEASED;
                        tok_next.entry = MY_NUM;
                        tok_next.rkey  = tok_in.key;
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg      <= 1'b0;
            tok_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            used_reg      <= used_next;
            tok_valid_reg <= tok_valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            key_reg <= key_next;
            tok_reg <= tok_next;
        end
    end

    assign tok_valid_out = tok_valid_reg;
    assign tok_out       = tok_reg;

endmodule

### hdl/kst_out_stage.sv
// end of the cell row: settles unmatched requests and holds the result item
module kst_out_stage (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              advance,
    input  logic                              tok_valid,
    input  kst_pkg::kst_token_t               tok,
    output logic                              out_valid,
    output logic [kst_pkg::CODE_W-1:0]        result_code,
    output logic [kst_pkg::ENTRY_W-1:0]       result_entry,
    output logic [kst_pkg::KEY_W-1:0]         result_key
);

    logic                          out_valid_reg;
    logic [kst_pkg::CODE_W-1:0]    code_reg;
    logic [kst_pkg::CODE_W-1:0]    code_next;
    logic [kst_pkg::ENTRY_W-1:0]   entry_reg;
    logic [kst_pkg::ENTRY_W-1:0]   entry_next;
    logic [kst_pkg::KEY_W-1:0]     key_reg;
    logic [kst_pkg::KEY_W-1:0]     key_next;

    always_comb
    begin
        code_next  = tok.code;
        entry_next = tok.entry;
        key_next   = tok.rkey;
        if (!tok.done)
        begin
            key_next = tok.key;
            unique case (tok.kind)
                kst_pkg::REQ_ALLOC:
                begin
                    code_next  = kst_pkg::RES_FULL;
                    entry_next = '0;
                end
                kst_pkg::REQ_QUERY:
                begin
                    // no cell matched the number, so it is out of range
                    code_next  = kst_pkg::RES_INVALID;
                    entry_next = tok.num;
                end
                kst_pkg::REQ_RELEASE:
                begin
                    code_next  = kst_pkg::RES_NOT_FOUND;
                    entry_next = '0;
                end
                default:
                begin
                    code_next  = kst_pkg::RES_UNKNOWN;
                    entry_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= tok_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            code_reg  <= code_next;
            entry_reg <= entry_next;
            key_reg   <= key_next;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_code  = code_reg;
    assign result_entry = entry_reg;
    assign result_key   = key_reg;

endmodule

### hdl/keyed_slot_table_core.sv
// keyed slot table top level: row of entry cells and result register
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+------------------------------------
//  request  | in        | in_valid/in_stall  | req_type, item_key, entry_number
//  result   | out       | out_valid/out_stall| result_code, result_entry, result_key
//
// each request item walks the row of NUM_SLOTS cells, one cell per cycle while the
// row advances, then passes the result register
// the row is a shift line: a new item may enter every cycle while in_stall is low,
// and meets each cell after the item ahead of it has updated it
// the whole row and the result register freeze while a result waits under
// out_stall, and in_stall is high exactly then; reset frees every entry
module keyed_slot_table_core #(
    parameter int NUM_SLOTS = kst_pkg::NUM_SLOTS_DEFAULT
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [kst_pkg::KIND_W-1:0]    req_type,
    input  logic [kst_pkg::KEY_W-1:0]     item_key,
    input  logic [kst_pkg::ENTRY_W-1:0]   entry_number,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [kst_pkg::CODE_W-1:0]    result_code,
    output logic [kst_pkg::ENTRY_W-1:0]   result_entry,
    output logic [kst_pkg::KEY_W-1:0]     result_key
);

    // global shift enable for the row and the result register
    logic                 advance;
    logic                 tok_valid [0:NUM_SLOTS];
    kst_pkg::kst_token_t  tok       [0:NUM_SLOTS];

    assign advance  = !out_valid || !out_stall;
    assign in_stall = !advance;

    // fresh token from the request fields, nothing resolved yet
    assign tok_valid[0] = in_valid;
    assign tok[0]       = '{kind:  req_type,
                            key:   item_key,
                            num:   entry_number,
                            done:  1'b0,
                            code:  kst_pkg::RES_UNKNOWN,
                            entry: '0,
                            rkey:  item_key};

    // cell i holds entry number i + 1; the lowest match wins because the
    // token is marked done at the first cell that takes it
    for (genvar i = 0; i < NUM_SLOTS; i++)
    begin : g_cell
        kst_cell #(
            .CELL_NUM (i + 1)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .advance       (advance),
            .tok_valid_in  (tok_valid[i]),
            .tok_in        (tok[i]),
            .tok_valid_out (tok_valid[i+1]),
            .tok_out       (tok[i+1])
        );
    end

    // unmatched allocate, release, query and unknown kinds are settled here
    kst_out_stage u_out (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (advance),
        .tok_valid    (tok_valid[NUM_SLOTS]),
        .tok          (tok[NUM_SLOTS]),
        .out_valid    (out_valid),
        .result_code  (result_code),
        .result_entry (result_entry),
        .result_key   (result_key)
    );

endmodule
